// ----- hdl/tlsed_pkg.sv -----
// ----------------------------------------------------------------------------
// TLS extension list deframer package
// Result kinds, error codes and the result record shared by the deframer
// and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsed_pkg;

   // Kind of a result item.
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   // Error codes carried with an error result.
   localparam logic [1:0] ERR_SHORT    = 2'd0;
   localparam logic [1:0] ERR_MISMATCH = 2'd1;
   localparam logic [1:0] ERR_TRUNC    = 2'd2;

   // Byte count saturates at the top of its range.
   localparam int unsigned SEEN_W = 17;

   // Result queue depth; two free entries are needed to take an item.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Packed widths on the ports.
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned RSP_USER_W = 2;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] ext_code;
      logic [15:0] ext_size;
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic [1:0]  error_code;
   } result_type;

endpackage : tlsed_pkg

`default_nettype wire

// ----- hdl/tls_extension_list_deframer.sv -----
// A result item is written into the result queue when the input item that
// causes it is accepted, and is shown on the rsp_ side from the queue head.
// Throughput: one input item per cycle while each item causes at most one
// result and the consumer takes each one; an item causing a final result as
// well gives two, drained by the single result port from a four-entry queue.
// Reset (synchronous, active high) clears the parser and the queue.
// ----------------------------------------------------------------------------
// TLS extension list deframer
// Parses a byte stream of TLS extension blocks into header, payload and
// closing results, with a small result queue towards the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_extension_list_deframer
   import tlsed_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input item channel.
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tlast,   // block_end
   // Result item channel.
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] ext_code,
                                                   // [31:16] ext_size,
                                                   // [39:32] payload_byte,
                                                   // [41:40] error_code,
                                                   // [47:42] zero
   output      logic [RSP_USER_W-1:0] rsp_tuser,   // [1:0] result_kind
   output      logic                  rsp_tlast    // payload_last
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = PTR_W + 1;
   localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

   typedef enum logic [2:0] {
      PH_LEN_HI  = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_CODE_HI = 3'd2,
      PH_CODE_LO = 3'd3,
      PH_SIZE_HI = 3'd4,
      PH_SIZE_LO = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [15:0]       length_ff, length_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [15:0]       code_ff, code_in;
   logic [7:0]        size_hi_ff, size_hi_in;
   logic [15:0]       left_ff, left_in;

   result_type        queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              accept;
   logic              pop;
   logic [7:0]        data_byte;
   logic              prim_valid;
   result_type        prim_res;
   logic              fin_valid;
   result_type        fin_res;
   logic [15:0]       size_word;
   phase_type         phase_step;
   logic [15:0]       length_step;
   result_type        wr_res0;
   logic [1:0]        push_cnt;
   result_type        head;

   assign data_byte  = req_tdata[7:0];
   assign req_tready = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign accept     = req_tvalid & req_tready;
   assign size_word  = {size_hi_ff, data_byte};

   // Field parser: state update and results for the byte at the port.
   always_comb begin
      phase_step  = phase_ff;
      length_step = length_ff;
      code_in     = code_ff;
      size_hi_in  = size_hi_ff;
      left_in     = left_ff;
      prim_valid  = 1'b0;
      prim_res    = '0;
      seen_in     = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + SEEN_W'(1);

      unique case (phase_ff)
         PH_LEN_LO: begin
            length_step = {length_ff[15:8], data_byte};
            phase_step  = PH_CODE_HI;
         end
         PH_CODE_HI: begin
            code_in    = {data_byte, 8'h00};
            phase_step = PH_CODE_LO;
         end
         PH_CODE_LO: begin
            code_in    = {code_ff[15:8], data_byte};
            phase_step = PH_SIZE_HI;
         end
         PH_SIZE_HI: begin
            size_hi_in = data_byte;
            phase_step = PH_SIZE_LO;
         end
         PH_SIZE_LO: begin
            prim_valid        = 1'b1;
            prim_res.kind     = KIND_HEADER;
            prim_res.ext_code = code_ff;
            prim_res.ext_size = size_word;
            if (size_word == 16'd0) begin
               phase_step = PH_CODE_HI;
            end else begin
               left_in    = size_word;
               phase_step = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            prim_valid            = 1'b1;
            prim_res.kind         = KIND_PAYLOAD;
            prim_res.payload_byte = data_byte;
            prim_res.payload_last = (left_ff == 16'd1);
            left_in               = left_ff - 16'd1;
            if (left_ff == 16'd1) begin
               phase_step = PH_CODE_HI;
            end
         end
         default: begin
            length_step = {data_byte, 8'h00};
            phase_step  = PH_LEN_LO;
         end
      endcase

      // Closing result on the block's last byte.
      fin_valid = req_tlast;
      fin_res   = '0;
      fin_res.kind = KIND_ERROR;
      priority if (seen_in < SEEN_W'(2)) begin
         fin_res.error_code = ERR_SHORT;
      end else if (seen_in != ({1'b0, length_step} + SEEN_W'(2))) begin
         fin_res.error_code = ERR_MISMATCH;
      end else if (phase_step != PH_CODE_HI) begin
         fin_res.error_code = ERR_TRUNC;
      end else begin
         fin_res.kind = KIND_DONE;
      end

      phase_in  = phase_step;
      length_in = length_step;
      if (req_tlast) begin
         phase_in   = PH_LEN_HI;
         length_in  = '0;
         seen_in    = '0;
         code_in    = '0;
         size_hi_in = '0;
         left_in    = '0;
      end
   end

   // Result queue bookkeeping: up to two writes and one read a cycle.
   always_comb begin
      pop       = rsp_tvalid & rsp_tready;
      wr_res0   = prim_valid ? prim_res : fin_res;
      push_cnt  = accept ? ({1'b0, prim_valid} + {1'b0, fin_valid}) : 2'd0;
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   // Parser state and queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN_HI;
         length_ff  <= '0;
         seen_ff    <= '0;
         code_ff    <= '0;
         size_hi_ff <= '0;
         left_ff    <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            length_ff  <= length_in;
            seen_ff    <= seen_in;
            code_ff    <= code_in;
            size_hi_ff <= size_hi_in;
            left_ff    <= left_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= wr_res0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= fin_res;
      end
   end

   // Head of the queue drives the result channel.
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.payload_last;
   assign rsp_tdata  = {6'd0, head.error_code, head.payload_byte,
                        head.ext_size, head.ext_code};

endmodule : tls_extension_list_deframer

`default_nettype wire

// ----- hdl/tlsed_checker.sv -----
// ----------------------------------------------------------------------------
// TLS extension list deframer port checker
// Watches the deframer's ports for result items that break the field rules.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsed_checker
   import tlsed_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser,
   input wire logic                  rsp_tlast
);

   logic unused_req;
   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata) ^ req_tlast;

   // The queue is empty straight after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item shown straight after reset");

   // A stalled result item stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // The last-payload mark only comes with payload items.
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PAYLOAD)
      else $error("payload_last set on a non-payload item");

   // Only error items carry an error code.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_ERROR |-> rsp_tdata[41:40] == 2'd0)
      else $error("error code on a non-error item");

   // Code and size fields are zero except on header items.
   a_header_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_HEADER |-> rsp_tdata[31:0] == 32'd0)
      else $error("header fields set on a non-header item");

endmodule : tlsed_checker

bind tls_extension_list_deframer tlsed_checker u_tlsed_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// TLS extension list deframer testbench
// Streams extension blocks into the deframer byte by byte and checks every
// header, payload and closing item against a parser kept in the bench. The
// blocks are directed corner cases, then random blocks (mostly well formed,
// the rest mismatched, truncated, short or noise); the last stretch of random
// blocks runs with no idling on either side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import tlsed_pkg::*;

   // Longest stretch without any handshake before the run is given up. The
   // long receiver hold-off below (HOLD_CYCLES) and the random gaps are far
   // shorter, so this is many times the slowest correct stall.
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned RANDOM_ITEMS = 1800;
   localparam int unsigned CALM_ITEMS = 300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam logic [SEEN_W-1:0] SEEN_TOP = '1;

   // Parser phases, one per field of the block.
   typedef enum logic [2:0] {
      PH_LEN_HI  = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_CODE_HI = 3'd2,
      PH_CODE_LO = 3'd3,
      PH_SIZE_HI = 3'd4,
      PH_SIZE_LO = 3'd5,
      PH_PAYLOAD = 3'd6
   } parse_phase_type;

   // Kinds of random block.
   typedef enum int {
      BLK_GOOD,
      BLK_MISMATCH,
      BLK_TRUNC,
      BLK_SHORT,
      BLK_NOISE
   } block_shape_type;

   // One input item: a raw byte and the end-of-block flag.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [7:0] data_byte
   logic                  req_tlast = 1'b0;  // block_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [15:0] ext_code, [31:16] ext_size,
                                             // [39:32] payload_byte,
                                             // [41:40] error_code, [47:42] zero
   logic [RSP_USER_W-1:0] rsp_tuser;         // [1:0] result_kind
   logic                  rsp_tlast;         // payload_last

   tls_extension_list_deframer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock and the single reset at the start.
   always #5 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   byte_item_type req_pending[$];
   result_type    rsp_expected[$];
   logic [7:0]    blk[$];
   int unsigned   fail_count = 0;
   int unsigned   bytes_taken = 0;
   int unsigned   bytes_loaded = 0;
   int unsigned   calm_from = 32'hFFFF_FFFF;
   int unsigned   idle_cycles = 0;
   logic          calm = 1'b0;

   // Parser state of the bench.
   parse_phase_type   phase_q = PH_LEN_HI;
   logic [15:0]       block_len_q = '0;
   logic [SEEN_W-1:0] seen_q = '0;
   logic [15:0]       code_q = '0;
   logic [15:0]       size_q = '0;
   logic [15:0]       left_q = '0;

   function automatic result_type make_result(kind_type kind, logic [15:0] code,
                                              logic [15:0] size, logic [7:0] pbyte,
                                              logic plast, logic [1:0] err);
      result_type r;
      r.kind = kind;
      r.ext_code = code;
      r.ext_size = size;
      r.payload_byte = pbyte;
      r.payload_last = plast;
      r.error_code = err;
      return r;
   endfunction

   // Advances the bench parser by one byte and queues the items it gives.
   function automatic void parse_byte(logic [7:0] b, logic fin);
      if (seen_q != SEEN_TOP) seen_q = seen_q + 1'b1;
      case (phase_q)
         PH_LEN_LO: begin
            block_len_q = {block_len_q[15:8], b};
            phase_q = PH_CODE_HI;
         end
         PH_CODE_HI: begin
            code_q = {b, 8'h00};
            phase_q = PH_CODE_LO;
         end
         PH_CODE_LO: begin
            code_q = {code_q[15:8], b};
            phase_q = PH_SIZE_HI;
         end
         PH_SIZE_HI: begin
            size_q = {b, 8'h00};
            phase_q = PH_SIZE_LO;
         end
         PH_SIZE_LO: begin
            size_q = {size_q[15:8], b};
            rsp_expected.push_back(make_result(KIND_HEADER, code_q, size_q,
                                               8'h00, 1'b0, 2'd0));
            if (size_q == 16'd0) begin
               phase_q = PH_CODE_HI;
            end else begin
               left_q = size_q;
               phase_q = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            rsp_expected.push_back(make_result(KIND_PAYLOAD, 16'h0, 16'h0, b,
                                               left_q == 16'd1, 2'd0));
            left_q = left_q - 16'd1;
            if (left_q == 16'd0) phase_q = PH_CODE_HI;
         end
         default: begin
            block_len_q = {b, 8'h00};
            phase_q = PH_LEN_LO;
         end
      endcase

      // Closing item on the flagged byte; the mismatch check wins over
      // truncation.
      if (fin) begin
         if (seen_q < SEEN_W'(2))
            rsp_expected.push_back(make_result(KIND_ERROR, 16'h0, 16'h0, 8'h00,
                                               1'b0, ERR_SHORT));
         else if (seen_q != {1'b0, block_len_q} + 17'd2)
            rsp_expected.push_back(make_result(KIND_ERROR, 16'h0, 16'h0, 8'h00,
                                               1'b0, ERR_MISMATCH));
         else if (phase_q != PH_CODE_HI)
            rsp_expected.push_back(make_result(KIND_ERROR, 16'h0, 16'h0, 8'h00,
                                               1'b0, ERR_TRUNC));
         else
            rsp_expected.push_back(make_result(KIND_DONE, 16'h0, 16'h0, 8'h00,
                                               1'b0, 2'd0));
         phase_q = PH_LEN_HI;
         block_len_q = '0;
         seen_q = '0;
         code_q = '0;
         size_q = '0;
         left_q = '0;
      end
   endfunction

   // Block building: the body is collected in blk, the length is put in
   // front, and the whole block is moved to the pending items.
   task automatic put_ext(logic [15:0] code, int unsigned size);
      logic [15:0] sz;
      sz = size[15:0];
      blk.push_back(code[15:8]);
      blk.push_back(code[7:0]);
      blk.push_back(sz[15:8]);
      blk.push_back(sz[7:0]);
      repeat (size) blk.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic prefix_length(logic [15:0] len);
      blk.push_front(len[7:0]);
      blk.push_front(len[15:8]);
   endtask

   task automatic flush_block();
      byte_item_type it;
      foreach (blk[i]) begin
         it.data = blk[i];
         it.last = (i == blk.size() - 1);
         req_pending.push_back(it);
      end
      blk.delete();
   endtask

   function automatic int unsigned pick_size();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 5) return 0;
      if (r < 19) return $urandom_range(1, 12);
      return $urandom_range(13, 60);
   endfunction

   task automatic fill_good_body(int unsigned min_ext);
      int unsigned n_ext;
      n_ext = $urandom_range(min_ext, 4);
      repeat (n_ext) put_ext(16'($urandom), pick_size());
   endtask

   task automatic add_random_block();
      int unsigned     pick;
      block_shape_type shape;
      logic [15:0]     len;
      int unsigned     cut;
      pick = $urandom_range(0, 99);
      if (pick < 70) shape = BLK_GOOD;
      else if (pick < 80) shape = BLK_MISMATCH;
      else if (pick < 90) shape = BLK_TRUNC;
      else if (pick < 95) shape = BLK_SHORT;
      else shape = BLK_NOISE;
      case (shape)
         BLK_GOOD: begin
            fill_good_body(0);
            prefix_length(16'(blk.size()));
         end
         BLK_MISMATCH: begin
            fill_good_body(0);
            len = 16'(blk.size());
            if ($urandom_range(0, 1) == 0) len = len + 16'($urandom_range(1, 3));
            else len = 16'($urandom);
            if (len == 16'(blk.size())) len = len + 16'd1;
            prefix_length(len);
         end
         BLK_TRUNC: begin
            fill_good_body(1);
            cut = $urandom_range(1, blk.size() - 1);
            while (blk.size() > cut) void'(blk.pop_back());
            prefix_length(16'(blk.size()));
         end
         BLK_SHORT: begin
            blk.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            repeat ($urandom_range(2, 20)) blk.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      flush_block();
   endtask

   // Sender: offers pending items, with random gaps except near the end.
   int unsigned   send_gap = 0;
   byte_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tlast);
            bytes_taken = bytes_taken + 1;
         end
         calm = (bytes_loaded >= calm_from);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 15) - 1;
               req_tvalid <= 1'b0;
            end else if (req_pending.size() > 0) begin
               next_item = req_pending.pop_front();
               bytes_loaded = bytes_loaded + 1;
               req_tdata <= next_item.data;
               req_tlast <= next_item.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result item and stalls at random, plus one long
   // hold-off so that the result queue fills and the input backs up.
   int unsigned rcv_gap = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   result_type  want;

   task automatic report(string field, logic [15:0] exp_v, logic [15:0] act_v);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual kind %0d",
                        $time, rsp_tuser);
               fail_count = fail_count + 1;
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_tuser !== want.kind)
                  report("result_kind", 16'(want.kind), 16'(rsp_tuser));
               if (rsp_tdata[15:0] !== want.ext_code)
                  report("ext_code", want.ext_code, rsp_tdata[15:0]);
               if (rsp_tdata[31:16] !== want.ext_size)
                  report("ext_size", want.ext_size, rsp_tdata[31:16]);
               if (rsp_tdata[39:32] !== want.payload_byte)
                  report("payload_byte", 16'(want.payload_byte), 16'(rsp_tdata[39:32]));
               if (rsp_tdata[41:40] !== want.error_code)
                  report("error_code", 16'(want.error_code), 16'(rsp_tdata[41:40]));
               if (rsp_tdata[47:42] !== 6'd0)
                  report("tdata padding", 16'h0, 16'(rsp_tdata[47:42]));
               if (rsp_tlast !== want.payload_last)
                  report("payload_last", 16'(want.payload_last), 16'(rsp_tlast));
            end
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && bytes_taken >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (rcv_gap > 0) begin
            rcv_gap = rcv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rcv_gap = $urandom_range(1, 15) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: cycles in which neither side moves an item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("tls_extension_list_deframer test failed");
      $finish;
   end

   // Stimulus and end of run.
   initial begin
      // One-byte block: too short.
      blk.push_back(8'hFF);
      flush_block();
      // Empty block: done straight after the length.
      prefix_length(16'h0000);
      flush_block();
      // Empty extension with the top code: header and done on the last byte.
      put_ext(16'hFFFF, 0);
      prefix_length(16'(blk.size()));
      flush_block();
      // One payload byte on the last byte, then done.
      put_ext(16'h0000, 1);
      prefix_length(16'(blk.size()));
      flush_block();
      // Two bytes declaring the largest length: mismatch.
      blk.push_back(8'hFF);
      blk.push_back(8'hFF);
      flush_block();
      // Count matches but the header is cut short: truncated.
      put_ext(16'h0001, 0);
      void'(blk.pop_back());
      prefix_length(16'(blk.size()));
      flush_block();

      while (req_pending.size() < RANDOM_ITEMS - CALM_ITEMS) add_random_block();

      // Last stretch of blocks, sent and taken with no idling.
      calm_from = req_pending.size();
      while (req_pending.size() < RANDOM_ITEMS) add_random_block();

      while (reset) @(posedge clock);
      while (req_pending.size() != 0 || req_tvalid || rsp_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && rsp_expected.size() == 0)
         $display("tls_extension_list_deframer test passed");
      else
         $display("tls_extension_list_deframer test failed");
      $finish;
   end

endmodule : tb_top

`default_nettype wire
